// ===== rtl/srst_pkg.sv =====
`timescale 1ns / 1ps

package srst_pkg;

    // Field widths
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WDAY_W   = 3;
    localparam int MINUTE_W = 11;
    localparam int RELAY_W  = 8;
    localparam int CODES_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Signed working width for thresholds (covers -4096..4095)
    localparam int THR_W = 13;

    // Relays acted on: min(RELAY_COUNT, 8)
    localparam int RELAY_COUNT = 8;
    localparam int ACT_RELAYS  = (RELAY_COUNT < RELAY_W) ? RELAY_COUNT : RELAY_W;

    localparam logic [YEAR_W-1:0]       MIN_YEAR    = YEAR_W'(2020);
    localparam logic signed [THR_W-1:0] DAY_MINUTES = THR_W'(24 * 60);
    localparam logic [WDAY_W-1:0]       WDAY_NONE   = '0;
    localparam logic [WDAY_W-1:0]       DOW_LAST    = WDAY_W'(6);

    // State reset values
    localparam logic [YEAR_W-1:0]  RST_YEAR  = YEAR_W'(1970);
    localparam logic [MONTH_W-1:0] RST_MONTH = MONTH_W'(1);
    localparam logic [DAY_W-1:0]   RST_DAY   = DAY_W'(1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFF_HOUR = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MIN  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DAY_MASK = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIONS  = CFG_IDX_W'(5);

    typedef enum logic [2:0] {
        MODE_EXACT         = 3'd0,
        MODE_BEFORE_RISE   = 3'd1,
        MODE_AFTER_RISE    = 3'd2,
        MODE_BEFORE_SET    = 3'd3,
        MODE_AFTER_SET     = 3'd4
    } mode_t;

    // Relay action codes
    localparam logic [1:0] ACT_OFF    = 2'd0;
    localparam logic [1:0] ACT_ON     = 2'd1;
    localparam logic [1:0] ACT_INVERT = 2'd2;
    localparam logic [1:0] ACT_SKIP   = 2'd3;

    typedef struct packed {
        logic                 active;
        logic [2:0]           mode;
        logic [4:0]           offset_hour;
        logic [5:0]           offset_minute;
        logic [6:0]           day_mask;
        logic [CODES_W-1:0]   action_codes;
    } cfg_t;

    typedef struct packed {
        logic [RELAY_W-1:0]   current_relays;
        logic [MINUTE_W-1:0]  sunset_minute;
        logic [MINUTE_W-1:0]  sunrise_minute;
        logic [MINUTE_W-1:0]  minute_of_day;
        logic [WDAY_W-1:0]    week_day;
        logic [DAY_W-1:0]     cal_day;
        logic [MONTH_W-1:0]   cal_month;
        logic [YEAR_W-1:0]    cal_year;
    } tick_t;

    localparam int TICK_W = $bits(tick_t);

endpackage

// ===== rtl/sun_relative_schedule_trigger.sv =====
`timescale 1ns / 1ps

// Sun-relative schedule trigger.
// One input word per tick (date, weekday, minute of day, sunrise, sunset,
// current relay bits) enters on s_tvalid/s_tready; one result word per tick
// (fired, relays_out, changed) leaves on m_tvalid/m_tready.
// Config: cfg_we writes cfg_data into register cfg_index (0 active, 1 mode,
// 2 offset hour, 3 offset minute, 4 day mask, 5 action codes); write only
// while no tick is in flight.
// Two register stages: input register, then result register. A word is
// accepted into the input register, and m_tvalid rises once it moves on to
// the result register; throughput is one word per cycle unless m_tready stalls.
// The elapsed compare and the relay update are one short cone between the
// two registers; the last-date/last-elapsed state is updated as a tick of a
// year from 2020 on moves into the result register, so the tick behind it sees it at once.
// When the receiver stalls, the result word holds and the input register
// still fills; s_tready drops only when both stages hold a word and
// m_tready is low.
// Reset (rst_n low, asynchronous) empties both stages, restores the
// configuration defaults (inactive, action codes all skip) and sets the
// last date to 1970-01-01 with last-elapsed clear.
module sun_relative_schedule_trigger
#(
    parameter int RELAY_COUNT = srst_pkg::RELAY_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] cal_year, [15:12] cal_month, [20:16] cal_day, [23:21] week_day,
    // [34:24] minute_of_day, [45:35] sunrise_minute, [56:46] sunset_minute,
    // [64:57] current_relays, [71:65] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] fired, [8:1] relays_out, [9] changed, [15:10] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [srst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srst_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration
    srst_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active        <= 1'b0;
            cfg_reg.mode          <= srst_pkg::MODE_EXACT;
            cfg_reg.offset_hour   <= '0;
            cfg_reg.offset_minute <= '0;
            cfg_reg.day_mask      <= '0;
            cfg_reg.action_codes  <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srst_pkg::REG_ACTIVE:   cfg_reg.active        <= cfg_data[0];
                srst_pkg::REG_MODE:     cfg_reg.mode          <= cfg_data[2:0];
                srst_pkg::REG_OFF_HOUR: cfg_reg.offset_hour   <= cfg_data[4:0];
                srst_pkg::REG_OFF_MIN:  cfg_reg.offset_minute <= cfg_data[5:0];
                srst_pkg::REG_DAY_MASK: cfg_reg.day_mask      <= cfg_data[6:0];
                srst_pkg::REG_ACTIONS:  cfg_reg.action_codes  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic accept;

    srst_pkg::tick_t tick_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg <= srst_pkg::tick_t'(s_tdata[srst_pkg::TICK_W-1:0]);
        end
    end

    // Tick evaluation
    logic elapsed;
    logic valid_year;
    logic blocked;
    logic fire_now;
    logic [srst_pkg::RELAY_W-1:0] relays_calc;
    logic changed_calc;

    logic [srst_pkg::YEAR_W-1:0]  last_year_reg;
    logic [srst_pkg::MONTH_W-1:0] last_month_reg;
    logic [srst_pkg::DAY_W-1:0]   last_day_reg;
    logic                         last_elapsed_reg;

    srst_elapsed u_elapsed
    (
        .cfg            (cfg_reg),
        .week_day       (tick_reg.week_day),
        .minute_of_day  (tick_reg.minute_of_day),
        .sunrise_minute (tick_reg.sunrise_minute),
        .sunset_minute  (tick_reg.sunset_minute),
        .elapsed        (elapsed)
    );

    assign valid_year = tick_reg.cal_year >= srst_pkg::MIN_YEAR;
    // Fires only once per run of elapsed ticks, and never right after a
    // tick whose year, month or day field is lower than this tick's.
    assign blocked    = (last_year_reg < tick_reg.cal_year)
                        || (last_month_reg < tick_reg.cal_month)
                        || (last_day_reg < tick_reg.cal_day)
                        || last_elapsed_reg;
    assign fire_now   = valid_year && elapsed && !blocked;

    srst_action
    #(
        .RELAY_COUNT (RELAY_COUNT)
    )
    u_action
    (
        .fire         (fire_now),
        .action_codes (cfg_reg.action_codes),
        .relays_in    (tick_reg.current_relays),
        .relays_out   (relays_calc),
        .changed      (changed_calc)
    );

    // Date / elapsed history, updated as a valid tick moves to the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_year_reg    <= srst_pkg::RST_YEAR;
            last_month_reg   <= srst_pkg::RST_MONTH;
            last_day_reg     <= srst_pkg::RST_DAY;
            last_elapsed_reg <= 1'b0;
        end
        else if (advance && in_valid_reg && valid_year)
        begin
            last_year_reg    <= tick_reg.cal_year;
            last_month_reg   <= tick_reg.cal_month;
            last_day_reg     <= tick_reg.cal_day;
            last_elapsed_reg <= elapsed;
        end
    end

    // Result register
    logic                         fired_reg;
    logic [srst_pkg::RELAY_W-1:0] relays_reg;
    logic                         changed_reg;

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            fired_reg   <= fire_now;
            relays_reg  <= relays_calc;
            changed_reg <= changed_calc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, changed_reg, relays_reg, fired_reg};

    // Checks
    a_changed_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> !m_tdata[9])
        else $error("changed set on a word that did not fire");

    a_fire_marks_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && fire_now) |=> last_elapsed_reg)
        else $error("last elapsed not set after firing");

    a_old_year_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && !valid_year) |=>
            ($stable(last_year_reg) && $stable(last_elapsed_reg)))
        else $error("history changed on a tick before the minimum year");

endmodule

// ===== rtl/srst_elapsed.sv =====
`timescale 1ns / 1ps

// Elapsed check for one tick: threshold from mode/offset, day wrap, weekday mask.
module srst_elapsed
(
    input  srst_pkg::cfg_t                       cfg,
    input  logic [srst_pkg::WDAY_W-1:0]          week_day,
    input  logic [srst_pkg::MINUTE_W-1:0]        minute_of_day,
    input  logic [srst_pkg::MINUTE_W-1:0]        sunrise_minute,
    input  logic [srst_pkg::MINUTE_W-1:0]        sunset_minute,
    output logic                                 elapsed
);

    localparam int TW = srst_pkg::THR_W;

    logic [TW-1:0]                off_u;
    logic signed [TW-1:0]         off_s;
    logic signed [TW-1:0]         now_s;
    logic signed [TW-1:0]         sun_s;
    logic signed [TW-1:0]         thr_sub;
    logic signed [TW-1:0]         thr_add;
    logic signed [TW-1:0]         thr;
    logic [srst_pkg::WDAY_W-1:0]  dow;
    logic [srst_pkg::WDAY_W-1:0]  dow_next;
    logic [srst_pkg::WDAY_W-1:0]  dow_prev;
    logic [srst_pkg::WDAY_W-1:0]  dow_sel;
    logic                         mode_ok;

    assign off_u = TW'(cfg.offset_hour) * TW'(60) + TW'(cfg.offset_minute);
    assign off_s = $signed(off_u);
    assign now_s = $signed(TW'(minute_of_day));

    assign dow      = week_day - srst_pkg::WDAY_W'(1);
    assign dow_next = (dow == srst_pkg::DOW_LAST) ? '0 : dow + srst_pkg::WDAY_W'(1);
    assign dow_prev = (dow == '0) ? srst_pkg::DOW_LAST : dow - srst_pkg::WDAY_W'(1);

    always_comb
    begin
        sun_s   = $signed(TW'(sunrise_minute));
        thr     = off_s;
        dow_sel = dow;
        mode_ok = 1'b1;
        thr_sub = '0;
        thr_add = '0;
        case (cfg.mode)
            srst_pkg::MODE_EXACT:
            begin
                thr = off_s;
            end
            srst_pkg::MODE_BEFORE_RISE,
            srst_pkg::MODE_BEFORE_SET:
            begin
                if (cfg.mode == srst_pkg::MODE_BEFORE_SET)
                begin
                    sun_s = $signed(TW'(sunset_minute));
                end
                thr_sub = sun_s - off_s;
                if (thr_sub < 0)
                begin
                    thr     = thr_sub + srst_pkg::DAY_MINUTES;
                    dow_sel = dow_next;
                end
                else
                begin
                    thr = thr_sub;
                end
            end
            srst_pkg::MODE_AFTER_RISE,
            srst_pkg::MODE_AFTER_SET:
            begin
                if (cfg.mode == srst_pkg::MODE_AFTER_SET)
                begin
                    sun_s = $signed(TW'(sunset_minute));
                end
                thr_add = sun_s + off_s;
                if (thr_add >= srst_pkg::DAY_MINUTES)
                begin
                    thr     = thr_add - srst_pkg::DAY_MINUTES;
                    dow_sel = dow_prev;
                end
                else
                begin
                    thr = thr_add;
                end
            end
            default:
            begin
                mode_ok = 1'b0;
            end
        endcase
    end

    assign elapsed = cfg.active && (week_day != srst_pkg::WDAY_NONE) && mode_ok
                     && cfg.day_mask[dow_sel] && (now_s >= thr);

endmodule

// ===== rtl/srst_action.sv =====
`timescale 1ns / 1ps

// Per-relay set / clear / invert / skip, applied only when the schedule fires.
module srst_action
#(
    parameter int RELAY_COUNT = srst_pkg::RELAY_COUNT
)
(
    input  logic                                fire,
    input  logic [srst_pkg::CODES_W-1:0]        action_codes,
    input  logic [srst_pkg::RELAY_W-1:0]        relays_in,
    output logic [srst_pkg::RELAY_W-1:0]        relays_out,
    output logic                                changed
);

    // only relays that fit in the relay word are acted on
    localparam int ACT_N = (RELAY_COUNT < srst_pkg::RELAY_W) ? RELAY_COUNT
                                                              : srst_pkg::RELAY_W;

    logic [srst_pkg::RELAY_W-1:0] applied;

    always_comb
    begin
        applied = relays_in;
        for (int i = 0; i < ACT_N; i++)
        begin
            case (action_codes[2*i +: 2])
                srst_pkg::ACT_OFF:    applied[i] = 1'b0;
                srst_pkg::ACT_ON:     applied[i] = 1'b1;
                srst_pkg::ACT_INVERT: applied[i] = ~relays_in[i];
                srst_pkg::ACT_SKIP:   applied[i] = relays_in[i];
                default:              applied[i] = relays_in[i];
            endcase
        end
    end

    assign relays_out = fire ? applied : relays_in;
    assign changed    = fire && (applied != relays_in);

endmodule
